// ===== hw/rtl/btlv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER TLV header parser package
// Request/result payload types, the front-to-back command record and the
// fixed codes shared by the parser modules.
// ----------------------------------------------------------------------------
package btlv_pkg;

   localparam int AVAIL_W   = 16;
   localparam int BYTE_W    = 8;
   localparam int CONS_W    = 8;   // tag + length octets, at most 129
   localparam int LEFT_W    = 16;
   localparam int LENCNT_W  = 7;

   // Status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_MULTI_TAG = 2'd1;
   localparam logic [1:0] ST_OVERRUN   = 2'd2;

   // Tag and length octet masks
   localparam logic [7:0] TAG_NUM_MASK  = 8'h1F;
   localparam logic [7:0] LEN_LONG_FLAG = 8'h80;
   localparam logic [7:0] LEN_CNT_MASK  = 8'h7F;

   localparam logic [1:0] INT_TAG_RESET = 2'd2;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        start_req;
      logic [15:0] avail_bytes;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  tag;
      logic [15:0] content_len;
      logic [7:0]  header_len;
      logic [15:0] total_len;
      logic [31:0] int_value;
   } rsp_payload_type;

   // Classified byte handed from front to back
   typedef struct packed {
      logic        start;
      logic        multi_tag;
      logic        long_form;
      logic [6:0]  len_cnt;
      logic [7:0]  data_byte;
      logic [15:0] avail;
   } cmd_type;

endpackage

// ===== hw/rtl/ber_tlv_header_parser_unit.sv =====
`timescale 1ns / 1ps
// Path: a request is registered in the command queue; its result (if any) is
// then registered in the result queue and shown on the rsp_ ports.
// Throughput: one byte per cycle unless the result queue is full; the
// back-end state machine updates once per byte; both queues hold two entries.
// Reset: synchronous, active high; empties both queues, returns the parser to
// idle and sets integer_tag to 2. No clearing pass.
// ----------------------------------------------------------------------------
// BER TLV header parser unit
// Front end classifies request bytes into a short command queue; back end
// decodes tag and length, gathers integer content and queues results.
// ----------------------------------------------------------------------------
module ber_tlv_header_parser_unit
   import btlv_pkg::*;
#(
   parameter int LEN_BITS   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   output logic            req_full,
   input  req_payload_type req_data,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output rsp_payload_type rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [7:0]      csr_data
);

   logic    cmd_valid;
   logic    cmd_pop;
   cmd_type cmd;

   // Byte classification and command queue
   btlv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   // Header decode and result queue
   btlv_back #(
      .LEN_BITS   (LEN_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/btlv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER TLV front end
// Accepts request bytes, classifies them (start, multibyte tag, long-form
// length) and holds them in a two-entry command queue for the back end.
// ----------------------------------------------------------------------------
module btlv_front
   import btlv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   output logic            req_full,
   input  req_payload_type req_data,
   output logic            cmd_valid,
   input  logic            cmd_pop,
   output cmd_type         cmd
);

   cmd_type     q_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   cmd_type     cls;
   logic        push, pop;

   // Classify the incoming byte
   always_comb begin
      cls.start     = req_data.start_req;
      cls.multi_tag = ((req_data.data_byte & TAG_NUM_MASK) == TAG_NUM_MASK);
      cls.long_form = ((req_data.data_byte & LEN_LONG_FLAG) != 8'd0);
      cls.len_cnt   = 7'(req_data.data_byte & LEN_CNT_MASK);
      cls.data_byte = req_data.data_byte;
      cls.avail     = req_data.avail_bytes;
   end

   assign req_full  = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_push && !req_full;
   assign pop       = cmd_pop && cmd_valid;

   // Queue pointers and fill count
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("command queue count out of range");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("command queue lost a request");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("command queue pointers inconsistent with count");

endmodule

// ===== hw/rtl/btlv_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER TLV back end
// Runs the per-object header state machine on classified bytes, gathers
// integer content and pushes finished results into a two-entry result queue.
// ----------------------------------------------------------------------------
module btlv_back
   import btlv_pkg::*;
#(
   parameter int LEN_BITS   = 16,
   parameter int VALUE_BITS = 32
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            cmd_valid,
   output logic            cmd_pop,
   input  cmd_type         cmd,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [7:0]      csr_data,
   output logic            rsp_empty,
   input  logic            rsp_pop,
   output rsp_payload_type rsp_data
);

   localparam int ACC_W = (LEN_BITS + 1 > AVAIL_W) ? LEN_BITS + 1 : AVAIL_W;
   localparam int SUM_W = ACC_W + 1;
   localparam logic [LEN_BITS:0]   LEN_SAT   = {1'b1, {LEN_BITS{1'b0}}};
   localparam logic [LEN_BITS+8:0] LEN_SAT_W = {{8{1'b0}}, LEN_SAT};

   // Phase codes
   localparam logic [2:0] PH_IDLE  = 3'd0;
   localparam logic [2:0] PH_LEN1  = 3'd1;
   localparam logic [2:0] PH_LENX  = 3'd2;
   localparam logic [2:0] PH_VALUE = 3'd3;

   logic [2:0]            phase_ff, phase_in;
   logic [CONS_W-1:0]     consumed_ff, consumed_in;
   logic [AVAIL_W-1:0]    avail_ff, avail_in;
   logic [LENCNT_W-1:0]   lbl_ff, lbl_in;
   logic [BYTE_W-1:0]     tag_ff, tag_in;
   logic [LEN_BITS:0]     len_acc_ff, len_acc_in;
   logic [VALUE_BITS-1:0] val_acc_ff, val_acc_in;
   logic [LEFT_W-1:0]     val_left_ff, val_left_in;
   logic [7:0]            int_tag_ff;

   rsp_payload_type       oq_ff [2];
   logic                  owr_ff, owr_in;
   logic                  ord_ff, ord_in;
   logic [1:0]            ocount_ff, ocount_in;
   logic                  out_full, opop;

   logic                  fire;
   logic [CONS_W-1:0]     cons1;
   logic [LEN_BITS+8:0]   len_shift;
   logic [LEN_BITS:0]     len_next;
   logic [VALUE_BITS+7:0] val_shift;
   logic [VALUE_BITS-1:0] val_next;
   logic [LEN_BITS:0]     fin_len;
   logic [CONS_W-1:0]     fin_cons;
   logic [SUM_W-1:0]      sum;
   logic                  sum_over;
   logic                  res_valid;
   rsp_payload_type       res;

   // Configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         int_tag_ff <= 8'(INT_TAG_RESET);
      end else if (csr_valid) begin
         int_tag_ff <= csr_data;
      end
   end

   assign out_full = (ocount_ff == 2'd2);
   assign fire     = cmd_valid && !out_full;
   assign cmd_pop  = fire;

   // Shared datapath: next length, next value, header fit check
   always_comb begin
      cons1     = consumed_ff + CONS_W'(1);
      len_shift = {len_acc_ff, cmd.data_byte};
      len_next  = (len_shift > LEN_SAT_W) ? LEN_SAT : len_shift[LEN_BITS:0];
      val_shift = {val_acc_ff, cmd.data_byte};
      val_next  = val_shift[VALUE_BITS-1:0];
      case (phase_ff)
         PH_LEN1: begin
            fin_len  = cmd.long_form ? '0 : (LEN_BITS+1)'(cmd.data_byte);
            fin_cons = cons1;
         end
         PH_LENX: begin
            fin_len  = len_next;
            fin_cons = cons1;
         end
         default: begin
            fin_len  = len_acc_ff;
            fin_cons = consumed_ff;
         end
      endcase
      sum      = SUM_W'(fin_len) + SUM_W'(fin_cons);
      sum_over = (sum > SUM_W'(avail_ff));
   end

   // Header state machine
   always_comb begin
      phase_in    = phase_ff;
      consumed_in = consumed_ff;
      avail_in    = avail_ff;
      lbl_in      = lbl_ff;
      tag_in      = tag_ff;
      len_acc_in  = len_acc_ff;
      val_acc_in  = val_acc_ff;
      val_left_in = val_left_ff;
      res_valid   = 1'b0;
      res         = '0;
      res.tag     = tag_ff;

      if (fire) begin
         if (cmd.start) begin
            tag_in      = cmd.data_byte;
            avail_in    = cmd.avail;
            consumed_in = CONS_W'(1);
            len_acc_in  = '0;
            val_acc_in  = '0;
            val_left_in = '0;
            lbl_in      = '0;
            if (cmd.multi_tag) begin
               res_valid  = 1'b1;
               res.status = ST_MULTI_TAG;
               res.tag    = cmd.data_byte;
               phase_in   = PH_IDLE;
            end else begin
               phase_in = PH_LEN1;
            end
         end else begin
            case (phase_ff)
               PH_LEN1, PH_LENX: begin
                  consumed_in = cons1;
                  len_acc_in  = fin_len;
                  if (phase_ff == PH_LEN1) begin
                     lbl_in = cmd.len_cnt;
                  end else begin
                     lbl_in = lbl_ff - LENCNT_W'(1);
                  end
                  if (phase_ff == PH_LENX && ({{(AVAIL_W-CONS_W){1'b0}}, cons1} > avail_ff)) begin
                     // length octets ran past the available bytes
                     res_valid  = 1'b1;
                     res.status = ST_OVERRUN;
                     phase_in   = PH_IDLE;
                  end else if (phase_ff == PH_LEN1 && cmd.long_form && cmd.len_cnt != '0) begin
                     phase_in = PH_LENX;
                  end else if (phase_ff == PH_LENX && lbl_ff != LENCNT_W'(1)) begin
                     phase_in = PH_LENX;
                  end else if (sum_over) begin
                     res_valid  = 1'b1;
                     res.status = ST_OVERRUN;
                     phase_in   = PH_IDLE;
                  end else if (tag_ff == int_tag_ff && fin_len != '0) begin
                     val_acc_in  = '0;
                     val_left_in = LEFT_W'(fin_len);
                     phase_in    = PH_VALUE;
                  end else begin
                     res_valid       = 1'b1;
                     res.status      = ST_OK;
                     res.content_len = 16'(fin_len);
                     res.header_len  = 8'(fin_cons);
                     res.total_len   = 16'(sum);
                     res.int_value   = '0;
                     val_acc_in      = '0;
                     phase_in        = PH_IDLE;
                  end
               end
               PH_VALUE: begin
                  val_acc_in  = val_next;
                  val_left_in = val_left_ff - LEFT_W'(1);
                  if (val_left_ff == LEFT_W'(1)) begin
                     res_valid       = 1'b1;
                     res.status      = ST_OK;
                     res.content_len = 16'(len_acc_ff);
                     res.header_len  = 8'(consumed_ff);
                     res.total_len   = 16'(sum);
                     res.int_value   = 32'(val_next);
                     phase_in        = PH_IDLE;
                  end
               end
               default: begin
                  // continuation byte while idle: dropped
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      consumed_ff <= consumed_in;
      avail_ff    <= avail_in;
      lbl_ff      <= lbl_in;
      tag_ff      <= tag_in;
      len_acc_ff  <= len_acc_in;
      val_acc_ff  <= val_acc_in;
      val_left_ff <= val_left_in;
   end

   // Result queue
   assign rsp_empty = (ocount_ff == 2'd0);
   assign rsp_data  = oq_ff[ord_ff];
   assign opop      = rsp_pop && !rsp_empty;

   always_comb begin
      owr_in    = res_valid ? !owr_ff : owr_ff;
      ord_in    = opop ? !ord_ff : ord_ff;
      ocount_in = ocount_ff;
      if (res_valid && !opop) begin
         ocount_in = ocount_ff + 2'd1;
      end else if (opop && !res_valid) begin
         ocount_in = ocount_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owr_ff    <= 1'b0;
         ord_ff    <= 1'b0;
         ocount_ff <= 2'd0;
      end else begin
         owr_ff    <= owr_in;
         ord_ff    <= ord_in;
         ocount_ff <= ocount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         oq_ff[owr_ff] <= res;
      end
   end

   a_result_room: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (ocount_ff != 2'd2))
      else $error("result pushed into a full queue");

   a_value_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_VALUE) |-> (val_left_ff != '0))
      else $error("value phase with no bytes left");

   a_start_no_value: assert property (@(posedge clock) disable iff (reset)
      (fire && cmd.start) |=> (phase_ff != PH_VALUE))
      else $error("start byte led straight to value phase");

   a_lenx_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_LENX) |-> (lbl_ff != '0))
      else $error("long-form phase with no length octets left");

endmodule

// ===== sim/ber_tlv_header_parser_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER TLV header parser unit testbench
// Feeds byte streams of BER objects (well formed, truncated, overrunning and
// plain noise) through the request queue under random stalls on both sides,
// and checks every decoded header against a cycle-free software decoder.
// ----------------------------------------------------------------------------
module ber_tlv_header_parser_unit_test
   import btlv_pkg::*;
();

   localparam int          WATCHDOG_LIMIT = 4000;
   localparam int          SETTLE_CYCLES  = 4;     // pipeline depth plus margin
   localparam int          RANDOM_ITEMS   = 900;
   localparam int          PHASE_COUNT    = 6;
   localparam int          HOLD_AT        = 60;    // result count that starts the hold-off
   localparam int          HOLD_CYCLES    = 400;
   localparam logic [24:0] LEN_CEILING    = 25'h1_0000;

   typedef enum logic [1:0] {
      PARSE_IDLE,
      PARSE_LEN1,
      PARSE_LENX,
      PARSE_VALUE
   } parse_phase_type;

   // Decoder mirror plus the queue of headers it still expects to see
   class tlv_scoreboard;
      logic [7:0]      int_tag;
      parse_phase_type phase;
      logic [7:0]      hdr_count;
      logic [15:0]     avail_limit;
      logic [6:0]      octets_left;
      logic [7:0]      tag_held;
      logic [16:0]     len_acc;
      logic [31:0]     value_acc;
      logic [15:0]     value_left;
      rsp_payload_type header_q[$];
      int              errors;
      int              checked;

      function new();
         int_tag     = 8'(INT_TAG_RESET);
         phase       = PARSE_IDLE;
         hdr_count   = '0;
         avail_limit = '0;
         octets_left = '0;
         tag_held    = '0;
         len_acc     = '0;
         value_acc   = '0;
         value_left  = '0;
         errors      = 0;
         checked     = 0;
      endfunction

      function void set_integer_tag(logic [7:0] v);
         int_tag = v;
      endfunction

      function int pending();
         return header_q.size();
      endfunction

      function void queue_header(logic [1:0] st);
         rsp_payload_type e;
         e        = '0;
         e.status = st;
         e.tag    = tag_held;
         if (st == ST_OK) begin
            e.content_len = len_acc[15:0];
            e.header_len  = hdr_count;
            e.total_len   = 16'(len_acc[15:0] + 16'(hdr_count));
            e.int_value   = value_acc;
         end
         phase = PARSE_IDLE;
         header_q.push_back(e);
      endfunction

      // Length known: check the fit, then emit or start gathering the integer
      function void close_header();
         logic [17:0] need;
         need = len_acc + hdr_count;
         value_acc = '0;
         if (need > avail_limit) begin
            queue_header(ST_OVERRUN);
         end else if (tag_held == int_tag && len_acc != 0) begin
            value_left = len_acc[15:0];
            phase      = PARSE_VALUE;
         end else begin
            queue_header(ST_OK);
         end
      endfunction

      function void note_request(req_payload_type r);
         logic [24:0] grown;
         if (r.start_req) begin
            tag_held    = r.data_byte;
            avail_limit = r.avail_bytes;
            hdr_count   = 8'd1;
            len_acc     = '0;
            value_acc   = '0;
            value_left  = '0;
            octets_left = '0;
            if ((r.data_byte & TAG_NUM_MASK) == TAG_NUM_MASK)
               queue_header(ST_MULTI_TAG);
            else
               phase = PARSE_LEN1;
            return;
         end
         case (phase)
            PARSE_LEN1: begin
               hdr_count++;
               if ((r.data_byte & LEN_LONG_FLAG) != 0) begin
                  octets_left = 7'(r.data_byte & LEN_CNT_MASK);
                  len_acc     = '0;
                  if (octets_left == 0)
                     close_header();
                  else
                     phase = PARSE_LENX;
               end else begin
                  len_acc = 17'(r.data_byte);
                  close_header();
               end
            end
            PARSE_LENX: begin
               hdr_count++;
               grown = {len_acc, r.data_byte};
               if (grown > LEN_CEILING)
                  len_acc = LEN_CEILING[16:0];
               else
                  len_acc = grown[16:0];
               if (hdr_count > avail_limit) begin
                  queue_header(ST_OVERRUN);
               end else begin
                  octets_left--;
                  if (octets_left == 0)
                     close_header();
               end
            end
            PARSE_VALUE: begin
               value_acc = {value_acc[23:0], r.data_byte};
               value_left--;
               if (value_left == 0)
                  queue_header(ST_OK);
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
         if (want !== seen) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, seen);
            errors++;
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type e;
         if (header_q.size() == 0) begin
            $error("unexpected result: status %0d tag 0x%02h", got.status, got.tag);
            errors++;
            return;
         end
         e = header_q.pop_front();
         checked++;
         compare_field("status", 32'(e.status), 32'(got.status));
         compare_field("tag", 32'(e.tag), 32'(got.tag));
         compare_field("content_len", 32'(e.content_len), 32'(got.content_len));
         compare_field("header_len", 32'(e.header_len), 32'(got.header_len));
         compare_field("total_len", 32'(e.total_len), 32'(got.total_len));
         compare_field("int_value", e.int_value, got.int_value);
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            req_push;
   logic            req_full;
   req_payload_type req_data;
   logic            rsp_empty;
   logic            rsp_pop;
   rsp_payload_type rsp_data;
   logic            csr_valid;
   logic            csr_ready;
   logic [7:0]      csr_data;

   tlv_scoreboard board = new();
   int            items_sent;
   int            results_seen = 0;
   int            settings_used;
   int            idle_cycles = 0;
   bit            tx_steady;

   ber_tlv_header_parser_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   // One request; returns at the edge that accepted it
   task automatic push_request(input logic [7:0] b, input logic s, input logic [15:0] a);
      req_payload_type r;
      int              gap;
      r.data_byte   = b;
      r.start_req   = s;
      r.avail_bytes = a;
      gap = tx_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_full);
      board.note_request(r);
      items_sent++;
   endtask

   // Tag, length field and some content bytes of one object.
   // octets < 0 selects short form, else long form with that many octets.
   task automatic send_object(input logic [7:0] tag, input int clen, input int octets,
                              input int avail_adj, input int content);
      logic [7:0] len_bytes[$];
      longint     avail_val;
      if (octets < 0) begin
         len_bytes.push_back(8'(clen));
      end else begin
         len_bytes.push_back(LEN_LONG_FLAG | 8'(octets));
         for (int i = octets - 1; i >= 0; i--)
            len_bytes.push_back((i < 4) ? 8'(clen >> (8 * i)) : 8'h00);
      end
      avail_val = 1 + len_bytes.size() + clen + avail_adj;
      if (avail_val < 0)
         avail_val = 0;
      if (avail_val > 65535)
         avail_val = 65535;
      push_request(tag, 1'b1, 16'(avail_val));
      foreach (len_bytes[i])
         push_request(len_bytes[i], 1'b0, 16'($urandom));
      for (int i = 0; i < content; i++)
         push_request(8'($urandom), 1'b0, 16'($urandom));
   endtask

   task automatic send_random_object();
      int         pick;
      int         clen;
      int         octets;
      int         adj;
      int         content;
      logic [7:0] tag;
      pick = $urandom_range(99);
      // noise: stray bytes and multibyte tags
      if (pick < 6) begin
         push_request(8'($urandom), 1'b0, 16'($urandom));
         return;
      end
      if (pick < 12) begin
         push_request(8'($urandom) | TAG_NUM_MASK, 1'b1, 16'($urandom));
         return;
      end
      tag = (pick < 50) ? board.int_tag : 8'($urandom);
      pick = $urandom_range(99);
      if (pick < 70)
         clen = $urandom_range(0, 8);
      else if (pick < 90)
         clen = $urandom_range(9, 127);
      else if (pick < 98)
         clen = $urandom_range(128, 2000);
      else
         clen = $urandom_range(2001, 70000);
      if (tag == board.int_tag && clen > 64)
         clen = $urandom_range(0, 64);
      pick = $urandom_range(99);
      if (clen < 128 && pick < 60) begin
         octets = -1;
      end else if (pick >= 95) begin
         octets = 0;
         clen   = 0;
      end else begin
         octets = (clen < 256) ? 1 : (clen < 65536) ? 2 : 3;
         if ($urandom_range(4) == 0)
            octets += $urandom_range(1, 2);
      end
      pick = $urandom_range(99);
      if (pick < 80)
         adj = $urandom_range(0, 20);
      else if (pick < 90)
         adj = 0;
      else
         adj = 0 - int'($urandom_range(1, 3));
      // integer content mostly complete, sometimes cut short by the next tag
      if (tag == board.int_tag)
         content = ($urandom_range(9) == 0) ? $urandom_range(0, clen) : clen;
      else
         content = $urandom_range(0, (clen < 6) ? clen : 6);
      send_object(tag, clen, octets, adj, content);
   endtask

   // Register write only once the parser has drained
   task automatic write_integer_tag(input logic [7:0] v);
      req_push <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.set_integer_tag(v);
      settings_used++;
   endtask

   // Result side: random pops, steady runs, one long hold-off
   initial begin
      int gap_left;
      int steady_left;
      gap_left    = 0;
      steady_left = 0;
      rsp_pop <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_pop && !rsp_empty) begin
            board.check_result(rsp_data);
            results_seen++;
            if (results_seen == HOLD_AT) begin
               gap_left = HOLD_CYCLES;
            end else if (steady_left > 0) begin
               steady_left--;
            end else if ($urandom_range(15) == 0) begin
               steady_left = 30;
            end else begin
               gap_left = pick_gap();
            end
         end
         if (gap_left > 0) begin
            rsp_pop <= 1'b0;
            gap_left--;
         end else begin
            rsp_pop <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin
      logic [7:0] tag_plan [PHASE_COUNT];
      int         phase_end;
      items_sent    = 0;
      settings_used = 0;
      tx_steady     = 1'b0;
      reset     <= 1'b1;
      req_push  <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_data  <= '0;
      tag_plan[0] = 8'h00;
      tag_plan[1] = 8'hFF;
      tag_plan[2] = 8'($urandom);
      tag_plan[3] = 8'h30;
      tag_plan[4] = 8'($urandom);
      tag_plan[5] = 8'(INT_TAG_RESET);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: stray bytes while idle
      push_request(8'h00, 1'b0, 16'h0000);
      push_request(8'hFF, 1'b0, 16'hFFFF);
      // integer: plain, empty, wider than 32 bits, long-form length
      send_object(8'h02, 4, -1, 0, 4);
      send_object(8'h02, 0, -1, 0, 0);
      send_object(8'h02, 6, -1, 0, 6);
      send_object(8'h02, 3, 1, 0, 3);
      // largest short form, exact fit
      send_object(8'h00, 127, -1, 0, 0);
      // multibyte tags
      push_request(8'hFF, 1'b1, 16'hFFFF);
      push_request(8'h1F, 1'b1, 16'h0000);
      // long form with no length octets
      send_object(8'h30, 0, 0, 0, 0);
      send_object(8'h04, 300, 2, 0, 0);
      // content one byte past the available bytes
      send_object(8'h04, 10, -1, -1, 0);
      // nothing available at all
      push_request(8'h05, 1'b1, 16'h0000);
      push_request(8'h00, 1'b0, 16'hFFFF);
      // length octets run past the available bytes
      push_request(8'h04, 1'b1, 16'd2);
      push_request(8'h83, 1'b0, 16'h0000);
      push_request(8'h00, 1'b0, 16'h0000);
      // huge long-form lengths saturate
      send_object(8'h04, 32'h00FF_FFFF, 3, 0, 0);
      send_object(8'h04, 32'h7FFF_FFFF, 4, 0, 0);
      // integer cut short by a new tag
      send_object(8'h02, 4, -1, 0, 2);
      // 127 length octets: largest header
      send_object(8'h04, 5, 127, 0, 0);
      // content filling the whole 16-bit available range
      send_object(8'h04, 65531, 2, 0, 0);

      // Random phases, one integer_tag setting each
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_integer_tag(tag_plan[p]);
         phase_end = items_sent + RANDOM_ITEMS / PHASE_COUNT;
         while (items_sent < phase_end) begin
            if ($urandom_range(19) == 0)
               tx_steady = !tx_steady;
            send_random_object();
         end
      end

      // Drain
      req_push <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES * 2) @(posedge clock);

      $display("Covered %0d request bytes under %0d integer_tag settings.",
               items_sent, settings_used + 1);
      $display("Checked %0d decoded headers, %0d mismatches.", board.checked, board.errors);
      if (board.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
